[sv/tfb_pkg.sv]
// Package for the telemetry frame builder: frame constants, state and byte-list types.
// No dependencies; imported by tfb_item_calc and telemetry_frame_builder.
`timescale 1ns / 1ps

package tfb_pkg;

    localparam int unsigned MAX_WAVE_ELEMENTS = 125;
    localparam int unsigned SENSOR_ELEMENTS   = 6;

    // Five header bytes, four data bytes and the checksum.
    localparam int unsigned MAX_BYTES = 10;

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] CODE_WAVE   = 8'hF1;
    localparam logic [7:0] CODE_SENSOR = 8'hF2;

    localparam logic FUNC_WAVE   = 1'b0;
    localparam logic FUNC_SENSOR = 1'b1;

    localparam logic [1:0] CFG_SENDER = 2'd0;
    localparam logic [1:0] CFG_TARGET = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    localparam logic [6:0] MAX_WAVE_COUNT = 7'(MAX_WAVE_ELEMENTS);
    localparam logic [6:0] SENSOR_COUNT   = 7'(SENSOR_ELEMENTS);
    localparam logic [7:0] SENSOR_LENGTH  = 8'((SENSOR_ELEMENTS * 4) % 256);

    typedef struct packed {
        logic       in_frame;
        logic       frame_kind;
        logic [6:0] elements_left;
        logic [7:0] running_sum;
    } t_frame_state;

    typedef logic [MAX_BYTES-1:0][7:0] t_byte_list;

endpackage

[sv/telemetry_frame_builder.sv]
// Top level of the telemetry frame builder: input stage, byte shifter, frame state.
// Depends on tfb_pkg and tfb_item_calc.
`timescale 1ns / 1ps

// Telemetry frame builder. Each accepted element is turned into its frame bytes
// (header 0xAA, sender, target, function code and length on a start element, then
// two waveform or four sensor bytes, then the additive checksum when the frame
// closes) and those bytes leave one per output transfer, with o_frame_end set on
// the checksum. Each byte an element produces takes one output transfer, so the
// single byte output is what limits the element rate: a waveform element carries two
// data bytes and a sensor element four, plus any header and checksum bytes. The
// input register takes a new element while the previous one's bytes are still
// draining, and elements outside a frame are dropped with no output. The sensor
// multiply (Q16.16 value times sensor_scale) is done as the element is captured.
// Configuration writes take effect at once and are meant for idle periods only.
module telemetry_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Element input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic        i_frame_start,
    input  logic [6:0]  i_element_count,
    input  logic [15:0] i_wave_sample,
    input  logic signed [31:0] i_sensor_value,
    // Byte output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import tfb_pkg::*;

    // Configuration registers
    logic [7:0]  r_sender_address;
    logic [7:0]  r_target_address;
    logic [15:0] r_sensor_scale;

    // Input stage
    logic        r_a_valid;
    logic        r_a_func;
    logic        r_a_start;
    logic [6:0]  r_a_count;
    logic [15:0] r_a_sample;
    logic [47:0] r_a_prod;

    // Output shifter
    logic        r_b_valid;
    t_byte_list  r_b_bytes;
    logic [3:0]  r_b_left;
    logic        r_b_end;

    t_frame_state r_st;
    t_frame_state n_st;

    t_byte_list   calc_bytes;
    logic [3:0]   calc_cnt;
    logic         calc_closes;

    logic         in_take;
    logic         out_take;
    logic         out_last;
    logic         a_move;
    logic signed [48:0] prod_full;

    assign out_take = r_b_valid && !i_stall;
    assign out_last = out_take && (r_b_left == 4'd1);
    // Hand the captured element over once the shifter is empty or drains this cycle.
    assign a_move   = r_a_valid && (!r_b_valid || out_last);
    assign o_stall  = r_a_valid && !a_move;
    assign in_take  = i_valid && !o_stall;

    assign prod_full = i_sensor_value * $signed({1'b0, r_sensor_scale});

    tfb_item_calc u_calc (
        .i_func           (r_a_func),
        .i_frame_start    (r_a_start),
        .i_element_count  (r_a_count),
        .i_wave_sample    (r_a_sample),
        .i_product        (r_a_prod),
        .i_sender_address (r_sender_address),
        .i_target_address (r_target_address),
        .i_state          (r_st),
        .o_bytes          (calc_bytes),
        .o_byte_cnt       (calc_cnt),
        .o_closes         (calc_closes),
        .o_state          (n_st)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sender_address <= 8'd0;
            r_target_address <= 8'd0;
            r_sensor_scale   <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENDER: r_sender_address <= i_cfg_data[7:0];
                CFG_TARGET: r_target_address <= i_cfg_data[7:0];
                CFG_SCALE:  r_sensor_scale   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Capture an element; the product is registered before any further arithmetic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_func   <= i_func;
            r_a_start  <= i_frame_start;
            r_a_count  <= i_element_count;
            r_a_sample <= i_wave_sample;
            r_a_prod   <= prod_full[47:0];
        end
    end

    // Frame state advances as each element moves into the shifter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (a_move) begin
            r_st <= n_st;
        end
    end

    // Load the byte list, or shift one byte out per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_left  <= 4'd0;
        end else if (a_move && (calc_cnt != 4'd0)) begin
            r_b_valid <= 1'b1;
            r_b_left  <= calc_cnt;
        end else if (out_last) begin
            r_b_valid <= 1'b0;
            r_b_left  <= 4'd0;
        end else if (out_take) begin
            r_b_left  <= r_b_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move && (calc_cnt != 4'd0)) begin
            r_b_bytes <= calc_bytes;
            r_b_end   <= calc_closes;
        end else if (out_take) begin
            r_b_bytes <= {8'd0, r_b_bytes[MAX_BYTES-1:1]};
        end
    end

    assign o_valid     = r_b_valid;
    assign o_out_byte  = r_b_bytes[0];
    assign o_frame_end = r_b_valid && r_b_end && (r_b_left == 4'd1);

    // A shown byte always has a count behind it.
    a_valid_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_left != 4'd0))
        else $error("output valid with empty byte count");

    // The checksum marker falls only on the last byte of a list.
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_end |-> (r_b_left == 4'd1))
        else $error("frame end on a byte that is not last");

    // An open frame always has elements still to come.
    a_open_frame_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.in_frame |-> (r_st.elements_left != 7'd0))
        else $error("open frame with no elements left");

    // A stalled input stage keeps its element.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_a_valid)
        else $error("input element lost while stalled");

    // A closed frame leaves the running sum cleared.
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && calc_closes) |=> (r_st.running_sum == 8'd0 && !r_st.in_frame))
        else $error("frame closed without clearing state");

endmodule

[sv/tfb_item_calc.sv]
// Per-element byte generation: header, data bytes, checksum and next frame state.
// Depends on tfb_pkg.
`timescale 1ns / 1ps

module tfb_item_calc (
    input  logic                i_func,
    input  logic                i_frame_start,
    input  logic [6:0]          i_element_count,
    input  logic [15:0]         i_wave_sample,
    input  logic [47:0]         i_product,
    input  logic [7:0]          i_sender_address,
    input  logic [7:0]          i_target_address,
    input  tfb_pkg::t_frame_state i_state,
    output tfb_pkg::t_byte_list o_bytes,
    output logic [3:0]          o_byte_cnt,
    output logic                o_closes,
    output tfb_pkg::t_frame_state o_state
);
    import tfb_pkg::*;

    logic [31:0] scaled;
    logic [6:0]  clamped;
    logic [6:0]  left;
    logic [7:0]  sum;
    logic [3:0]  pos;
    logic        kind;
    logic        emit_data;
    logic        close;

    // Q16.16 times scale, truncated toward zero; the 48-bit product always fits int32
    // after the shift, so no saturation is reachable.
    always_comb begin
        scaled = i_product[47:16];
        if (i_product[47] && (i_product[15:0] != 16'd0)) begin
            scaled = i_product[47:16] + 32'd1;
        end
    end

    assign clamped = (i_element_count > MAX_WAVE_COUNT) ? MAX_WAVE_COUNT : i_element_count;

    always_comb begin
        o_bytes   = '0;
        o_state   = i_state;
        pos       = 4'd0;
        sum       = i_state.running_sum;
        left      = i_state.elements_left;
        kind      = i_state.frame_kind;
        emit_data = 1'b0;
        close     = 1'b0;

        if (i_frame_start) begin
            sum  = 8'd0;
            kind = i_func;
            o_bytes[pos] = HDR_BYTE;         sum = sum + HDR_BYTE;         pos = pos + 4'd1;
            o_bytes[pos] = i_sender_address; sum = sum + i_sender_address; pos = pos + 4'd1;
            o_bytes[pos] = i_target_address; sum = sum + i_target_address; pos = pos + 4'd1;
            if (i_func == FUNC_WAVE) begin
                o_bytes[pos] = CODE_WAVE;        sum = sum + CODE_WAVE;        pos = pos + 4'd1;
                o_bytes[pos] = {clamped, 1'b0};  sum = sum + {clamped, 1'b0};  pos = pos + 4'd1;
                left = clamped;
            end else begin
                o_bytes[pos] = CODE_SENSOR;   sum = sum + CODE_SENSOR;   pos = pos + 4'd1;
                o_bytes[pos] = SENSOR_LENGTH; sum = sum + SENSOR_LENGTH; pos = pos + 4'd1;
                left = SENSOR_COUNT;
            end
            if (left == 7'd0) begin
                close = 1'b1;
            end else begin
                emit_data = 1'b1;
            end
        end else if (i_state.in_frame) begin
            emit_data = 1'b1;
        end

        if (emit_data) begin
            if (kind == FUNC_WAVE) begin
                o_bytes[pos] = i_wave_sample[15:8]; sum = sum + i_wave_sample[15:8];
                pos = pos + 4'd1;
                o_bytes[pos] = i_wave_sample[7:0];  sum = sum + i_wave_sample[7:0];
                pos = pos + 4'd1;
            end else begin
                o_bytes[pos] = scaled[31:24]; sum = sum + scaled[31:24]; pos = pos + 4'd1;
                o_bytes[pos] = scaled[23:16]; sum = sum + scaled[23:16]; pos = pos + 4'd1;
                o_bytes[pos] = scaled[15:8];  sum = sum + scaled[15:8];  pos = pos + 4'd1;
                o_bytes[pos] = scaled[7:0];   sum = sum + scaled[7:0];   pos = pos + 4'd1;
            end
            left = left - 7'd1;
            if (left == 7'd0) begin
                close = 1'b1;
            end
        end

        if (i_frame_start || i_state.in_frame) begin
            o_state.frame_kind = kind;
            if (close) begin
                o_bytes[pos]          = sum;
                pos                   = pos + 4'd1;
                o_state.in_frame      = 1'b0;
                o_state.elements_left = 7'd0;
                o_state.running_sum   = 8'd0;
            end else begin
                o_state.in_frame      = 1'b1;
                o_state.elements_left = left;
                o_state.running_sum   = sum;
            end
        end

        o_byte_cnt = pos;
        o_closes   = close;
    end

endmodule

[bench/tb_top.sv]
// Self-checking bench for telemetry_frame_builder: directed, pressure and random tests.
// Depends on tfb_pkg and the telemetry_frame_builder RTL; predicts every output byte itself.
`timescale 1ns / 1ps

module tb_top;
    import tfb_pkg::*;

    // Hold the bench to these bounds; the watchdog is far above the slowest legal run.
    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned REPORT_MAX    = 10;

    typedef struct {
        logic              func;
        logic              frame_start;
        logic [6:0]        element_count;
        logic [15:0]       wave_sample;
        logic signed [31:0] sensor_value;
    } t_element;

    typedef struct {
        logic [7:0] value;
        logic       closes;
    } t_frame_byte;

    // DUT ports; the inputs are known from time zero.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_func = 1'b0;
    logic               i_frame_start = 1'b0;
    logic [6:0]         i_element_count = '0;
    logic [15:0]        i_wave_sample = '0;
    logic signed [31:0] i_sensor_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_frame_end;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;

    // Frame predictor state and its copy of the registers.
    logic [7:0]  pred_sum = '0;
    logic [6:0]  pred_left = '0;
    logic        pred_open = 1'b0;
    logic        pred_kind = 1'b0;
    logic [7:0]  reg_sender = 8'd0;
    logic [7:0]  reg_target = 8'd0;
    logic [15:0] reg_scale = 16'd1;

    t_frame_byte expected_bytes[$];
    t_frame_byte oldest;

    int unsigned data_items = 0;     // elements that were not dropped
    int unsigned bytes_checked = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles = 0;

    telemetry_frame_builder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_frame_start   (i_frame_start),
        .i_element_count (i_element_count),
        .i_wave_sample   (i_wave_sample),
        .i_sensor_value  (i_sensor_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_frame_end     (o_frame_end),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort the run if it hangs anywhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Count down a long output hold-off independently of the sender.
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Check each byte transfer against the oldest prediction, then drive the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_bytes.size() == 0) begin
                error_count <= error_count + 1;
                if (error_count < REPORT_MAX) begin
                    $display("byte %0d: none expected, got %h end %b",
                             bytes_checked, o_out_byte, o_frame_end);
                end
            end else begin
                oldest = expected_bytes.pop_front();
                if (o_out_byte !== oldest.value || o_frame_end !== oldest.closes) begin
                    error_count <= error_count + 1;
                    if (error_count < REPORT_MAX) begin
                        $display("byte %0d: expected %h end %b, got %h end %b",
                                 bytes_checked, oldest.value, oldest.closes,
                                 o_out_byte, o_frame_end);
                    end
                end
            end
            bytes_checked <= bytes_checked + 1;
        end
        i_stall <= (hold_cycles != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic void push_frame_byte(input logic [7:0] value);
        expected_bytes.push_back('{value: value, closes: 1'b0});
        pred_sum = pred_sum + value;
    endfunction

    function automatic void push_checksum();
        expected_bytes.push_back('{value: pred_sum, closes: 1'b1});
        pred_sum  = '0;
        pred_left = '0;
        pred_open = 1'b0;
    endfunction

    // Q16.16 reading times the unsigned scale, truncated toward zero, clamped to int32.
    function automatic logic [31:0] scaled_reading(input logic signed [31:0] raw);
        longint reading;
        longint scale;
        longint product;
        reading = raw;
        scale   = reg_scale;
        product = (reading * scale) / 65536;
        if (product > 64'sh7FFF_FFFF) product = 64'sh7FFF_FFFF;
        if (product < -64'sh8000_0000) product = -64'sh8000_0000;
        return product[31:0];
    endfunction

    // Queue the bytes that one accepted element produces; return 0 when it is dropped.
    function automatic bit predict_frame_bytes(input t_element e);
        logic [6:0]  count;
        logic [31:0] scaled;
        if (e.frame_start) begin
            // A start abandons any open frame without its checksum.
            pred_sum  = '0;
            pred_kind = e.func;
            pred_open = 1'b1;
            push_frame_byte(HDR_BYTE);
            push_frame_byte(reg_sender);
            push_frame_byte(reg_target);
            if (pred_kind == FUNC_WAVE) begin
                count = (e.element_count > MAX_WAVE_COUNT) ? MAX_WAVE_COUNT : e.element_count;
                push_frame_byte(CODE_WAVE);
                push_frame_byte({count, 1'b0});     // two bytes per sample
                pred_left = count;
            end else begin
                push_frame_byte(CODE_SENSOR);
                push_frame_byte(SENSOR_LENGTH);
                pred_left = SENSOR_COUNT;
            end
            // Empty waveform frame: close at once and drop the sample.
            if (pred_left == 7'd0) begin
                push_checksum();
                return 1'b1;
            end
        end else if (!pred_open) begin
            return 1'b0;
        end

        if (pred_kind == FUNC_WAVE) begin
            push_frame_byte(e.wave_sample[15:8]);
            push_frame_byte(e.wave_sample[7:0]);
        end else begin
            scaled = scaled_reading(e.sensor_value);
            push_frame_byte(scaled[31:24]);
            push_frame_byte(scaled[23:16]);
            push_frame_byte(scaled[15:8]);
            push_frame_byte(scaled[7:0]);
        end
        pred_left = pred_left - 7'd1;
        if (pred_left == 7'd0) push_checksum();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic t_element make_element(input logic func, input logic start,
                                              input logic [6:0] count,
                                              input logic [15:0] sample,
                                              input logic [31:0] value);
        t_element e;
        e.func          = func;
        e.frame_start   = start;
        e.element_count = count;
        e.wave_sample   = sample;
        e.sensor_value  = value;
        return e;
    endfunction

    // Mix extremes, small signed readings (exercise truncation) and full-range noise.
    function automatic logic [31:0] rand_reading();
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2: return 32'($urandom_range(32'h7FFFF)) - 32'h3FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one element, wait for its transfer, then predict it. Leave valid high.
    task automatic send_element(input t_element e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= e.func;
        i_frame_start   <= e.frame_start;
        i_element_count <= e.element_count;
        i_wave_sample   <= e.wave_sample;
        i_sensor_value  <= e.sensor_value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        if (predict_frame_bytes(e)) data_items++;
    endtask

    // Drop valid, wait for every predicted byte, then let the block go quiet.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SENDER: reg_sender = value[7:0];
            CFG_TARGET: reg_target = value[7:0];
            CFG_SCALE:  reg_scale  = value;
            default: ;
        endcase
    endtask

    // Close an abandoned frame with an empty waveform start so the block goes idle.
    task automatic close_open_frame();
        if (pred_open) begin
            send_element(make_element(FUNC_WAVE, 1'b1, 7'd0, 16'($urandom), $urandom));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_outside_frame();
        send_element(make_element(FUNC_WAVE, 1'b0, 7'd3, 16'hFFFF, 32'hFFFF_FFFF));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd127, 16'h0000, 32'h0000_0000));
    endtask

    // Reset registers: addresses zero, unit scale.
    task automatic test_reset_registers();
        send_element(make_element(FUNC_WAVE, 1'b1, 7'd1, 16'hFFFF, 32'h0));
        send_element(make_element(FUNC_SENSOR, 1'b1, 7'd0, 16'h0, 32'h7FFF_FFFF));
        send_element(make_element(FUNC_WAVE, 1'b0, 7'd0, 16'h0, 32'h8000_0000));
        send_element(make_element(FUNC_WAVE, 1'b0, 7'd0, 16'h0, 32'hFFFF_FFFF));
        send_element(make_element(FUNC_WAVE, 1'b0, 7'd0, 16'h0, 32'h0000_0001));
        send_element(make_element(FUNC_WAVE, 1'b0, 7'd0, 16'h0, 32'h0001_0000));
        send_element(make_element(FUNC_WAVE, 1'b0, 7'd0, 16'h0, 32'hFFFE_8000));
    endtask

    // Largest addresses and scale against the sensor extremes.
    task automatic test_register_extremes();
        settle_block();
        write_reg(CFG_SENDER, 16'h00FF);
        write_reg(CFG_TARGET, 16'h00FF);
        write_reg(CFG_SCALE, 16'hFFFF);
        send_element(make_element(FUNC_SENSOR, 1'b1, 7'd127, 16'hFFFF, 32'h7FFF_FFFF));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0, 32'h8000_0000));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0, 32'hFFFF_FFFF));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0, 32'h0000_0001));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0, 32'h1234_5678));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0, 32'h0000_0000));
    endtask

    // Empty and oversized counts, restarts inside open frames, func on continuations.
    task automatic test_count_edges();
        send_element(make_element(FUNC_WAVE, 1'b1, 7'd0, 16'h1234, 32'h0));
        send_element(make_element(FUNC_WAVE, 1'b1, 7'd127, 16'h8000, 32'h0));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0001, 32'h7FFF_FFFF));
        send_element(make_element(FUNC_WAVE, 1'b1, 7'd126, 16'h7FFF, 32'h0));
        send_element(make_element(FUNC_SENSOR, 1'b1, 7'd5, 16'h0, 32'hC000_0000));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd0, 16'h0, 32'h4000_0000));
        send_element(make_element(FUNC_WAVE, 1'b1, 7'd2, 16'h00FF, 32'h0));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd64, 16'hFF00, 32'hFFFF_FFFF));
        send_element(make_element(FUNC_SENSOR, 1'b0, 7'd1, 16'hAAAA, 32'h1));
    endtask

    // Mostly complete frames with random content; some cut short, some stray elements.
    task automatic test_random_frames(input int unsigned items_wanted);
        int unsigned goal;
        int unsigned span;
        int unsigned k;
        logic        kind;
        logic [6:0]  count;
        goal = data_items + items_wanted;
        while (data_items < goal) begin
            if ($urandom_range(99) < 8) begin
                send_element(make_element(1'($urandom), 1'b0, 7'($urandom),
                                          16'($urandom), $urandom));
            end else begin
                kind  = 1'($urandom);
                count = 7'($urandom);
                if (kind == FUNC_SENSOR) begin
                    span = SENSOR_ELEMENTS;
                end else begin
                    // Keep most waveform frames short; a few use the full count range.
                    if ($urandom_range(99) >= 6) count = 7'($urandom_range(6));
                    span = (count == 0) ? 1 :
                           (count > MAX_WAVE_COUNT) ? MAX_WAVE_ELEMENTS : count;
                end
                // Cut long frames and some others short; the next start abandons them.
                if (span > 1 && (span > 10 || $urandom_range(99) < 10)) begin
                    span = $urandom_range(1, (span > 9) ? 8 : span - 1);
                end
                for (k = 0; k < span; k++) begin
                    send_element(make_element((k == 0) ? kind : 1'($urandom), k == 0,
                                              (k == 0) ? count : 7'($urandom),
                                              16'($urandom), rand_reading()));
                end
            end
        end
        close_open_frame();
    endtask

    // Hold the output off for a long stretch while a frame keeps coming in.
    task automatic test_output_holdoff();
        int unsigned k;
        hold_cycles <= 400;
        for (k = 0; k < 20; k++) begin
            send_element(make_element((k == 0) ? FUNC_WAVE : 1'($urandom), k == 0, 7'd20,
                                      16'($urandom), $urandom));
        end
    endtask

    // Pause the sender until every byte is out, then send a sensor frame.
    task automatic test_sender_pause();
        int unsigned k;
        settle_block();
        for (k = 0; k < SENSOR_ELEMENTS; k++) begin
            send_element(make_element(FUNC_SENSOR, k == 0, 7'($urandom),
                                      16'($urandom), rand_reading()));
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 83;
        test_outside_frame();
        test_reset_registers();
        test_register_extremes();
        test_count_edges();

        settle_block();
        write_reg(CFG_SENDER, 16'($urandom_range(255)));
        write_reg(CFG_TARGET, 16'($urandom_range(255)));
        write_reg(CFG_SCALE, 16'($urandom));
        test_random_frames(50);

        // Swap the idling sides; sender and scale go to zero, target to its largest value.
        settle_block();
        send_idle_pct = 83;
        recv_idle_pct = 34;
        write_reg(CFG_SENDER, 16'h0000);
        write_reg(CFG_TARGET, 16'h00FF);
        write_reg(CFG_SCALE, 16'h0000);
        test_random_frames(50);

        // Run at full rate with no idling on either side.
        settle_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_SENDER, 16'($urandom_range(255)));
        write_reg(CFG_TARGET, 16'($urandom_range(255)));
        write_reg(CFG_SCALE, 16'($urandom_range(1, 16'hFFFE)));
        test_random_frames(50);
        test_output_holdoff();
        test_sender_pause();

        settle_block();
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
